// ----- rtl/core/mqlf_pkg.sv -----
// ----------------------------------------------------------------------------
// mqlf_pkg
// shared types, constants and codes for the multi-queue linked fifo core
// ----------------------------------------------------------------------------
package mqlf_pkg;

   // default geometry
   localparam int NUM_QUEUES_DEF  = 8;
   localparam int NUM_ENTRIES_DEF = 64;

   // fixed field widths
   localparam int TICKET_BITS = 16;
   localparam int CLASS_BITS  = 2;
   localparam int QSEL_BITS   = 3;
   localparam int LEN_BITS    = 7;
   localparam int STATUS_BITS = 2;
   localparam int SIDE_BITS   = 2;

   // operation codes
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

   // shorter side codes
   localparam logic [SIDE_BITS-1:0] SIDE_EAST  = 2'd0;
   localparam logic [SIDE_BITS-1:0] SIDE_WEST  = 2'd1;
   localparam logic [SIDE_BITS-1:0] SIDE_EQUAL = 2'd2;

   // request item
   typedef struct packed {
      logic                   func;
      logic [CLASS_BITS-1:0]  ticket_class;
      logic                   entrance;
      logic [TICKET_BITS-1:0] ticket_number;
      logic [QSEL_BITS-1:0]   queue_select;
   } req_type;

   // response item
   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [TICKET_BITS-1:0] out_ticket;
      logic [CLASS_BITS-1:0]  out_class;
      logic [LEN_BITS-1:0]    queue_length;
      logic [SIDE_BITS-1:0]   shorter_side;
   } rsp_type;

   // controller to datapath strobes
   typedef struct packed {
      logic capture;
      logic rd_east;
      logic rd_west;
      logic rd_target;
      logic decide;
      logic exec;
      logic load_rsp;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic fail;
      logic free_empty;
      logic fresh_avail;
      logic rsp_free;
   } stat_type;

endpackage

// ----- rtl/core/multi_queue_linked_fifo_core.sv -----
// ----------------------------------------------------------------------------
// multi_queue_linked_fifo_core: NUM_QUEUES linked fifo queues (eight by default) over one entry store
// each item steps through capture, three length reads, decision, update and result;
// a full or empty report skips the update; no new item is taken until the last is done,
// as set by the sequencer and the single registered read port of the queue length store
// reset: synchronous; clears lengths and fill, sets the free count to full, no store clearing
// ----------------------------------------------------------------------------
module multi_queue_linked_fifo_core
   import mqlf_pkg::*;
#(
   parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   mqlf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // stores and response register
   mqlf_dp #(
      .NUM_QUEUES  (NUM_QUEUES),
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // no free entry means the never-used pool is gone too
   a_free_fresh: assert property (@(posedge clock) disable iff (reset)
      stat.free_empty |-> !stat.fresh_avail)
      else $error("free count zero with unused entries left");

   // an update only follows a passing decision
   a_exec_order: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> ($past(cmd.decide) && !$past(stat.fail)))
      else $error("update without a passing decision");

   // empty report carries no ticket and zero length
   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EMPTY) |->
      (rsp_data.queue_length == '0 && rsp_data.out_ticket == '0))
      else $error("empty report with data");

   // full report carries no ticket or class
   a_full_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
      (rsp_data.out_ticket == '0 && rsp_data.out_class == '0))
      else $error("full report with data");
`endif

endmodule

// ----- rtl/core/mqlf_ctrl.sv -----
// ----------------------------------------------------------------------------
// mqlf_ctrl
// sequencer that steps one item through count reads, decision and update
// ----------------------------------------------------------------------------
module mqlf_ctrl
   import mqlf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RD_E   = 3'd1;
   localparam logic [2:0] S_RD_W   = 3'd2;
   localparam logic [2:0] S_RD_Q   = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_EXEC   = 3'd5;
   localparam logic [2:0] S_RESULT = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and strobes
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_RD_E;
            end
         end
         S_RD_E: begin
            cmd.rd_east = 1'b1;
            state_in    = S_RD_W;
         end
         S_RD_W: begin
            cmd.rd_west = 1'b1;
            state_in    = S_RD_Q;
         end
         S_RD_Q: begin
            cmd.rd_target = 1'b1;
            state_in      = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = stat.fail ? S_RESULT : S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ----- rtl/core/mqlf_dp.sv -----
// ----------------------------------------------------------------------------
// mqlf_dp
// queue pointer, count and entry stores with free list and response register
// ----------------------------------------------------------------------------
module mqlf_dp
   import mqlf_pkg::*;
#(
   parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
)
(
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   output stat_type stat,
   input  req_type  req_data,
   input  logic     rsp_stall,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int QW = $clog2(NUM_QUEUES);
   localparam int AW = $clog2(NUM_ENTRIES);
   localparam int CW = $clog2(NUM_ENTRIES + 1);

   // reduce a small queue code to the queue range
   function automatic logic [QW-1:0] qmod(input logic [2:0] v);
      logic [3:0] r;
      r = {1'b0, v};
      for (int i = 0; i < 4; i++) begin
         if (int'(r) >= NUM_QUEUES) begin
            r = r - 4'(NUM_QUEUES);
         end
      end
      return QW'(r);
   endfunction

   // stores
   logic [CW-1:0]          cnt_mem    [NUM_QUEUES];
   logic [NUM_QUEUES-1:0]  cnt_vld_ff;
   logic [AW-1:0]          head_mem   [NUM_QUEUES];
   logic [AW-1:0]          tail_mem   [NUM_QUEUES];
   logic [AW-1:0]          link_mem   [NUM_ENTRIES];
   logic [TICKET_BITS-1:0] ticket_mem [NUM_ENTRIES];
   logic [CLASS_BITS-1:0]  class_mem  [NUM_ENTRIES];

   // registers
   req_type                req_ff;
   logic [CW-1:0]          cnt_rd_ff;
   logic                   cnt_rdv_ff;
   logic [CW-1:0]          east_ff;
   logic [CW-1:0]          west_ff;
   logic [AW-1:0]          head_rd_ff;
   logic [AW-1:0]          tail_rd_ff;
   logic [AW-1:0]          link_rd_ff;
   logic [TICKET_BITS-1:0] ticket_rd_ff;
   logic [CLASS_BITS-1:0]  class_rd_ff;
   logic [AW-1:0]          free_head_ff;
   logic [AW-1:0]          free_head_in;
   logic [CW-1:0]          free_cnt_ff;
   logic [CW-1:0]          free_cnt_in;
   logic [CW-1:0]          fill_ff;
   logic [CW-1:0]          fill_in;
   rsp_type                res_ff;
   rsp_type                res_in;
   rsp_type                rsp_data_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   // decoded request
   logic                   is_deq;
   logic [QW-1:0]          east_q;
   logic [QW-1:0]          west_q;
   logic [QW-1:0]          tgt_q;
   logic [QW-1:0]          cnt_raddr;
   logic                   cnt_re;
   logic [CW-1:0]          cnt_q;
   logic [SIDE_BITS-1:0]   side;
   logic [AW-1:0]          alloc_e;
   logic                   link_we;
   logic [AW-1:0]          link_waddr;
   logic [AW-1:0]          link_wdata;
   logic [AW-1:0]          link_raddr;
   logic [CW-1:0]          cnt_wdata;

   assign is_deq = (req_ff.func == FUNC_DEQ);
   assign east_q = qmod({req_ff.ticket_class, 1'b0});
   assign west_q = qmod({req_ff.ticket_class, 1'b1});
   assign tgt_q  = is_deq ? qmod(req_ff.queue_select)
                          : qmod({req_ff.ticket_class, req_ff.entrance});

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // count store read, one address per cycle
   assign cnt_re    = cmd.rd_east | cmd.rd_west | cmd.rd_target;
   assign cnt_raddr = cmd.rd_east ? east_q : (cmd.rd_west ? west_q : tgt_q);
   assign cnt_q     = cnt_rdv_ff ? cnt_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (cnt_re) begin
         cnt_rd_ff  <= cnt_mem[cnt_raddr];
         cnt_rdv_ff <= cnt_vld_ff[cnt_raddr];
      end
   end

   // hold the two class lengths
   always_ff @(posedge clock) begin
      if (cmd.rd_west) begin
         east_ff <= cnt_q;
      end
      if (cmd.rd_target) begin
         west_ff <= cnt_q;
      end
   end

   // shorter side from lengths before the update
   always_comb begin
      priority if (east_ff < west_ff) begin
         side = SIDE_EAST;
      end else if (west_ff < east_ff) begin
         side = SIDE_WEST;
      end else begin
         side = SIDE_EQUAL;
      end
   end

   // head and tail pointers of the target queue
   always_ff @(posedge clock) begin
      if (cmd.rd_target) begin
         head_rd_ff <= head_mem[tgt_q];
         tail_rd_ff <= tail_mem[tgt_q];
      end
   end

   // link and entry reads for the chosen entry
   assign link_raddr = is_deq ? head_rd_ff : free_head_ff;

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         link_rd_ff   <= link_mem[link_raddr];
         ticket_rd_ff <= ticket_mem[head_rd_ff];
         class_rd_ff  <= class_mem[head_rd_ff];
      end
   end

   // entry to allocate: never-used entries first, then the free list
   assign stat.fresh_avail = (fill_ff != CW'(NUM_ENTRIES));
   assign stat.free_empty  = (free_cnt_ff == '0);
   assign stat.fail        = is_deq ? (cnt_q == '0) : stat.free_empty;
   assign stat.rsp_free    = ~rsp_valid_ff | ~rsp_stall;
   assign alloc_e          = stat.fresh_avail ? AW'(fill_ff) : free_head_ff;

   // link write: dequeue pushes the entry on the free list,
   // enqueue chains the old tail to the new entry
   assign link_we    = cmd.exec & (is_deq | (cnt_q != '0));
   assign link_waddr = is_deq ? head_rd_ff : tail_rd_ff;
   assign link_wdata = is_deq ? free_head_ff : alloc_e;

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
   end

   // entry payload write on enqueue
   always_ff @(posedge clock) begin
      if (cmd.exec && !is_deq) begin
         ticket_mem[alloc_e] <= req_ff.ticket_number;
         class_mem[alloc_e]  <= req_ff.ticket_class;
      end
   end

   // queue pointer update
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (is_deq) begin
            head_mem[tgt_q] <= link_rd_ff;
         end else begin
            if (cnt_q == '0) begin
               head_mem[tgt_q] <= alloc_e;
            end
            tail_mem[tgt_q] <= alloc_e;
         end
      end
   end

   // queue length update
   assign cnt_wdata = is_deq ? (cnt_q - CW'(1)) : (cnt_q + CW'(1));

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         cnt_mem[tgt_q] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (cmd.exec) begin
         cnt_vld_ff[tgt_q] <= 1'b1;
      end
   end

   // free list bookkeeping
   always_comb begin
      free_head_in = free_head_ff;
      free_cnt_in  = free_cnt_ff;
      fill_in      = fill_ff;
      if (cmd.exec) begin
         if (is_deq) begin
            free_head_in = head_rd_ff;
            free_cnt_in  = free_cnt_ff + CW'(1);
         end else begin
            free_cnt_in = free_cnt_ff - CW'(1);
            if (stat.fresh_avail) begin
               fill_in = fill_ff + CW'(1);
            end else begin
               free_head_in = link_rd_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         free_cnt_ff  <= CW'(NUM_ENTRIES);
         fill_ff      <= '0;
      end else begin
         free_head_ff <= free_head_in;
         free_cnt_ff  <= free_cnt_in;
         fill_ff      <= fill_in;
      end
   end

   // result assembly
   always_comb begin
      res_in = res_ff;
      if (cmd.decide && stat.fail) begin
         res_in.status       = is_deq ? ST_EMPTY : ST_FULL;
         res_in.out_ticket   = '0;
         res_in.out_class    = '0;
         res_in.queue_length = LEN_BITS'(cnt_q);
         res_in.shorter_side = side;
      end else if (cmd.exec) begin
         res_in.status       = ST_OK;
         res_in.out_ticket   = is_deq ? ticket_rd_ff : '0;
         res_in.out_class    = is_deq ? class_rd_ff : '0;
         res_in.queue_length = LEN_BITS'(cnt_wdata);
         res_in.shorter_side = side;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // response output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
